// File: design/ccp_pkg.sv
// Shared types, constants and fixed-point helpers for the cuboid corner projection block.
`timescale 1ns / 1ps

package ccp_pkg;

    // Number of cuboid ids that are processed; ids at or above it are dropped.
    localparam int CUBOID_COUNT = 256;

    // Configuration register file.
    localparam int REG_COUNT = 6;
    localparam int CFG_IDX_W = 3;

    // Pipeline depths.
    localparam int TRIG_STAGES = 8;
    localparam int DIV_BITS    = 33;
    localparam int DIV_STAGES  = DIV_BITS + 2;
    localparam int WORLD_DEPTH = DIV_STAGES + 3;
    localparam int PIPE_DEPTH  = WORLD_DEPTH + 2;

    // Quarter-wave sine polynomial coefficients, Q2.30.
    localparam logic signed [31:0] SIN_C1 = 32'sd1686629713;
    localparam logic signed [31:0] SIN_C3 = -32'sd693598668;
    localparam logic signed [31:0] SIN_C5 = 32'sd85569306;
    localparam logic signed [31:0] SIN_C7 = -32'sd5026995;
    localparam logic signed [31:0] SIN_C9 = 32'sd172270;

    localparam logic [15:0] QUARTER_TURN = 16'd16384;
    localparam logic [2:0]  LAST_INDEX   = 3'd7;

    // Corner ordering: bit j set means negative x, negative y, or top face.
    localparam logic [7:0] CORNER_NEG_X = 8'b1000_0111;
    localparam logic [7:0] CORNER_NEG_Y = 8'b1011_0001;
    localparam logic [7:0] CORNER_TOP   = 8'b0110_0011;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Camera matrix, entry (row, col) at index row * 4 + col.
    typedef logic [11:0][31:0] mat_t;

    // One accepted cuboid.
    typedef struct packed {
        logic [7:0]         id;
        logic [30:0]        hx;
        logic [30:0]        hy;
        logic signed [31:0] h;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } cuboid_t;

    // One corner handed from the sequencer to the projection pipeline.
    typedef struct packed {
        logic [7:0]         tag;
        logic [2:0]         idx;
        logic               last;
        logic               neg_x;
        logic               neg_y;
        logic [30:0]        hx;
        logic [30:0]        hy;
        logic signed [31:0] z;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [17:0] sin;
        logic signed [17:0] cos;
    } corner_t;

    // Arithmetic shift right by n with rounding to nearest, ties away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] a, input int n);
        logic [63:0] mag;
        logic [63:0] half;
        mag  = a[63] ? (64'd0 - a) : a;
        half = 64'd1 << (n - 1);
        mag  = (mag + half) >> n;
        return a[63] ? $signed(64'd0 - mag) : $signed(mag);
    endfunction

    // True when a value lies outside the signed 32-bit range.
    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > 64'sh0000_0000_7FFF_FFFF) || (v < -64'sh0000_0000_8000_0000);
    endfunction

    // Saturate a value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = Q_MAX;
        end
        else if (v < -64'sh0000_0000_8000_0000) begin
            r = Q_MIN;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: design/ccp_sine_pipe.sv
// Eight-stage pipelined sine of a 16-bit binary angle, result in signed Q2.16.
`timescale 1ns / 1ps

module ccp_sine_pipe
    import ccp_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        angle,
    output logic signed [17:0] value
);

    logic [14:0]        arg;
    logic [30:0]        t_reg [1:6];
    logic               neg_reg [1:7];
    logic [30:0]        t2_reg [2:5];
    logic signed [33:0] p_reg [3:6];
    logic signed [33:0] pt_reg;
    logic signed [17:0] value_reg;

    logic [61:0]        tt;
    logic signed [63:0] m3;
    logic signed [63:0] m4;
    logic signed [63:0] m5;
    logic signed [63:0] m6;
    logic signed [63:0] m7;
    logic signed [63:0] f8;
    logic signed [17:0] clamp8;

    // Fold the angle into the first quadrant.
    always_comb
    begin
        arg = angle[14] ? (15'(QUARTER_TURN) - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    end

    // Horner steps, one multiply per stage.
    always_comb
    begin
        tt = t_reg[1] * t_reg[1];
        m3 = SIN_C9 * $signed({1'b0, t2_reg[2]});
        m4 = p_reg[3] * $signed({1'b0, t2_reg[3]});
        m5 = p_reg[4] * $signed({1'b0, t2_reg[4]});
        m6 = p_reg[5] * $signed({1'b0, t2_reg[5]});
        m7 = p_reg[6] * $signed({1'b0, t_reg[6]});
        f8 = rnd_shift(64'(pt_reg), 14);
        if (f8 < 64'sd0) begin
            clamp8 = 18'sd0;
        end
        else if (f8 > 64'sd65536) begin
            clamp8 = 18'sd65536;
        end
        else begin
            clamp8 = f8[17:0];
        end
    end

    // Stage registers advance together on enable.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[1]   <= {arg, 16'd0};
            neg_reg[1] <= angle[15];
            for (int i = 2; i <= 6; i++)
            begin
                t_reg[i] <= t_reg[i - 1];
            end
            for (int i = 2; i <= 7; i++)
            begin
                neg_reg[i] <= neg_reg[i - 1];
            end
            t2_reg[2] <= 31'((tt + 62'd536870912) >> 30);
            for (int i = 3; i <= 5; i++)
            begin
                t2_reg[i] <= t2_reg[i - 1];
            end
            p_reg[3]  <= 34'(64'(SIN_C7) + rnd_shift(m3, 30));
            p_reg[4]  <= 34'(64'(SIN_C5) + rnd_shift(m4, 30));
            p_reg[5]  <= 34'(64'(SIN_C3) + rnd_shift(m5, 30));
            p_reg[6]  <= 34'(64'(SIN_C1) + rnd_shift(m6, 30));
            pt_reg    <= 34'(rnd_shift(m7, 30));
            value_reg <= neg_reg[7] ? -clamp8 : clamp8;
        end
    end

    assign value = value_reg;

endmodule

// File: design/ccp_corner_gen.sv
// Corner sequencer: holds one cuboid and issues its eight corners in order.
`timescale 1ns / 1ps

module ccp_corner_gen
    import ccp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    input  cuboid_t            src,
    input  logic signed [17:0] src_sin,
    input  logic signed [17:0] src_cos,
    input  logic               adv,
    output logic               take,
    output logic               corner_valid,
    output corner_t            corner
);

    logic               busy_reg;
    logic [2:0]         cnt_reg;
    cuboid_t            cub_reg;
    logic signed [17:0] sin_reg;
    logic signed [17:0] cos_reg;

    // A new cuboid is taken when idle or as the last corner leaves.
    assign take = src_valid && (!busy_reg || (cnt_reg == LAST_INDEX && adv));

    // Sequencer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else if (take)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 3'd0;
        end
        else if (busy_reg && adv)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == LAST_INDEX)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Held cuboid data.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cub_reg <= src;
            sin_reg <= src_sin;
            cos_reg <= src_cos;
        end
    end

    // Current corner.
    always_comb
    begin
        corner.tag   = cub_reg.id;
        corner.idx   = cnt_reg;
        corner.last  = (cnt_reg == LAST_INDEX);
        corner.neg_x = CORNER_NEG_X[cnt_reg];
        corner.neg_y = CORNER_NEG_Y[cnt_reg];
        corner.hx    = cub_reg.hx;
        corner.hy    = cub_reg.hy;
        corner.z     = CORNER_TOP[cnt_reg] ? cub_reg.h : 32'sd0;
        corner.cx    = cub_reg.cx;
        corner.cy    = cub_reg.cy;
        corner.sin   = sin_reg;
        corner.cos   = cos_reg;
    end

    assign corner_valid = busy_reg;

endmodule

// File: design/ccp_div_lane.sv
// Pipelined Q16.16 divider lane, one quotient bit per stage, with saturation.
`timescale 1ns / 1ps

module ccp_div_lane
    import ccp_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [49:0] num,
    input  logic signed [49:0] den,
    output logic signed [31:0] quot,
    output logic               clip
);

    logic [49:0]        mag_n;
    logic [49:0]        mag_d;
    logic [65:0]        n_full;
    logic [65:0]        rem_reg [0:DIV_BITS];
    logic [DIV_BITS-1:0] q_reg [0:DIV_BITS];
    logic [49:0]        d_reg [0:DIV_BITS];
    logic               neg_reg [0:DIV_BITS];
    logic               ovf_reg [0:DIV_BITS];
    logic signed [31:0] quot_reg;
    logic               clip_reg;
    logic [DIV_BITS-1:0] qf;
    logic signed [31:0] quot_next;
    logic               clip_next;

    // Magnitudes, sign and quotient overflow check.
    always_comb
    begin
        mag_n  = num[49] ? (50'd0 - num) : num;
        mag_d  = den[49] ? (50'd0 - den) : den;
        n_full = {mag_n, 16'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= n_full;
            q_reg[0]   <= '0;
            d_reg[0]   <= mag_d;
            neg_reg[0] <= num[49] ^ den[49];
            ovf_reg[0] <= {17'd0, n_full} >= ({33'd0, mag_d} << DIV_BITS);
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar i = 1; i <= DIV_BITS; i++)
    begin : g_step
        localparam int K = DIV_BITS - i;
        logic hit;
        assign hit = (rem_reg[i - 1] >> K) >= {16'd0, d_reg[i - 1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= hit ? (rem_reg[i - 1] - ({16'd0, d_reg[i - 1]} << K))
                                  : rem_reg[i - 1];
                q_reg[i]   <= {q_reg[i - 1][DIV_BITS-2:0], hit};
                d_reg[i]   <= d_reg[i - 1];
                neg_reg[i] <= neg_reg[i - 1];
                ovf_reg[i] <= ovf_reg[i - 1];
            end
        end
    end

    // Apply the sign and saturate to the Q16.16 range.
    always_comb
    begin
        qf = q_reg[DIV_BITS];
        if (ovf_reg[DIV_BITS] || qf[DIV_BITS-1])
        begin
            clip_next = 1'b1;
            quot_next = neg_reg[DIV_BITS] ? Q_MIN : Q_MAX;
        end
        else if (!neg_reg[DIV_BITS])
        begin
            clip_next = qf[31];
            quot_next = qf[31] ? Q_MAX : $signed(qf[31:0]);
        end
        else if (qf[31] && (qf[30:0] != 31'd0))
        begin
            clip_next = 1'b1;
            quot_next = Q_MIN;
        end
        else
        begin
            clip_next = 1'b0;
            quot_next = $signed(32'd0 - qf[31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= quot_next;
            clip_reg <= clip_next;
        end
    end

    assign quot = quot_reg;
    assign clip = clip_reg;

endmodule

// File: design/ccp_project_pipe.sv
// Corner pipeline: rotation, translation, camera projection and division.
`timescale 1ns / 1ps

module ccp_project_pipe
    import ccp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  corner_t            in_corner,
    input  mat_t               mat,
    input  logic               out_stall,
    output logic               adv,
    output logic               out_valid,
    output logic [7:0]         cuboid_tag,
    output logic [2:0]         corner_index,
    output logic signed [31:0] world_x,
    output logic signed [31:0] world_y,
    output logic signed [31:0] world_z,
    output logic signed [31:0] image_u,
    output logic signed [31:0] image_v,
    output logic               zero_depth,
    output logic               clipped,
    output logic               last_corner
);

    typedef struct packed {
        logic [7:0]         tag;
        logic [2:0]         idx;
        logic               last;
        logic               zero;
        logic               clip;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } world_t;

    logic               vld_reg [0:PIPE_DEPTH-1];

    // Stage 1 and 2 registers.
    corner_t            c1_reg;
    corner_t            c2_reg;
    logic signed [49:0] chx_reg;
    logic signed [49:0] shy_reg;
    logic signed [49:0] chy_reg;
    logic signed [49:0] shx_reg;
    logic signed [35:0] rx_reg;
    logic signed [35:0] ry_reg;
    world_t             wp_reg [0:WORLD_DEPTH-1];
    logic signed [63:0] prod_reg [0:8];
    logic signed [49:0] u_reg;
    logic signed [49:0] v_reg;
    logic signed [49:0] w_reg;

    logic signed [50:0] rx_sum;
    logic signed [50:0] ry_sum;
    logic signed [63:0] x_full;
    logic signed [63:0] y_full;
    world_t             w3_next;
    world_t             w6_next;
    logic signed [63:0] row_sum [0:2];
    logic signed [31:0] quot_u;
    logic signed [31:0] quot_v;
    logic               clip_u;
    logic               clip_v;
    world_t             wo;

    // The whole pipeline moves unless a result waits on a stalled receiver.
    assign adv = !vld_reg[PIPE_DEPTH-1] || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i - 1];
            end
        end
    end

    // Rotation sums and translation with saturation.
    always_comb
    begin
        rx_sum = (c1_reg.neg_x ? -51'(chx_reg) : 51'(chx_reg))
               + (c1_reg.neg_y ? -51'(shy_reg) : 51'(shy_reg));
        ry_sum = (c1_reg.neg_y ? -51'(chy_reg) : 51'(chy_reg))
               - (c1_reg.neg_x ? -51'(shx_reg) : 51'(shx_reg));
        x_full = 64'(c2_reg.cx) + 64'(rx_reg);
        y_full = 64'(c2_reg.cy) + 64'(ry_reg);
        w3_next.tag  = c2_reg.tag;
        w3_next.idx  = c2_reg.idx;
        w3_next.last = c2_reg.last;
        w3_next.zero = 1'b0;
        w3_next.clip = ovf32(x_full) || ovf32(y_full);
        w3_next.x    = sat32(x_full);
        w3_next.y    = sat32(y_full);
        w3_next.z    = c2_reg.z;
    end

    // Rounded row sums of the camera matrix.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = rnd_shift(prod_reg[r * 3], 16)
                       + rnd_shift(prod_reg[r * 3 + 1], 16)
                       + rnd_shift(prod_reg[r * 3 + 2], 16)
                       + 64'($signed(mat[r * 4 + 3]));
        end
    end

    // World payload picks up the zero-depth flag beside the divider inputs.
    always_comb
    begin
        w6_next      = wp_reg[2];
        w6_next.zero = (w_reg == 50'sd0);
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg  <= in_corner;
            chx_reg <= in_corner.cos * $signed({1'b0, in_corner.hx});
            shy_reg <= in_corner.sin * $signed({1'b0, in_corner.hy});
            chy_reg <= in_corner.cos * $signed({1'b0, in_corner.hy});
            shx_reg <= in_corner.sin * $signed({1'b0, in_corner.hx});

            c2_reg <= c1_reg;
            rx_reg <= 36'(rnd_shift(64'(rx_sum), 16));
            ry_reg <= 36'(rnd_shift(64'(ry_sum), 16));

            wp_reg[0] <= w3_next;

            for (int r = 0; r < 3; r++)
            begin
                prod_reg[r * 3]     <= $signed(mat[r * 4])     * wp_reg[0].x;
                prod_reg[r * 3 + 1] <= $signed(mat[r * 4 + 1]) * wp_reg[0].y;
                prod_reg[r * 3 + 2] <= $signed(mat[r * 4 + 2]) * wp_reg[0].z;
            end
            wp_reg[1] <= wp_reg[0];

            u_reg     <= 50'(row_sum[0]);
            v_reg     <= 50'(row_sum[1]);
            w_reg     <= 50'(row_sum[2]);
            wp_reg[2] <= wp_reg[1];

            wp_reg[3] <= w6_next;
            for (int i = 4; i < WORLD_DEPTH; i++)
            begin
                wp_reg[i] <= wp_reg[i - 1];
            end
        end
    end

    // Two divider lanes share the depth of the world payload line.
    ccp_div_lane u_div_u (
        .clk  (clk),
        .en   (adv),
        .num  (u_reg),
        .den  (w_reg),
        .quot (quot_u),
        .clip (clip_u)
    );

    ccp_div_lane u_div_v (
        .clk  (clk),
        .en   (adv),
        .num  (v_reg),
        .den  (w_reg),
        .quot (quot_v),
        .clip (clip_v)
    );

    // Result fields.
    assign wo           = wp_reg[WORLD_DEPTH-1];
    assign out_valid    = vld_reg[PIPE_DEPTH-1];
    assign cuboid_tag   = wo.tag;
    assign corner_index = wo.idx;
    assign world_x      = wo.x;
    assign world_y      = wo.y;
    assign world_z      = wo.z;
    assign image_u      = wo.zero ? 32'sd0 : quot_u;
    assign image_v      = wo.zero ? 32'sd0 : quot_v;
    assign zero_depth   = wo.zero;
    assign clipped      = wo.clip || (!wo.zero && (clip_u || clip_v));
    assign last_corner  = wo.last;

endmodule

// File: design/cuboid_corner_projection.sv
// Top level of the cuboid corner projection block.
//
// Usage: the input channel (in_valid / in_stall) carries one cuboid per
// transfer: id, half extents, top height, ground centre and a 16-bit yaw.
// The output channel (out_valid / out_stall) delivers eight corner results
// per cuboid, corner 0 first, each with world and image coordinates.
// The camera matrix is loaded through cfg_write / cfg_index / cfg_data while
// the block is idle; indexes past the last register are ignored.
// Throughput: one corner per cycle while out_stall is low; the corner
// sequencer issues one corner per cycle unless stalled and sets this rate.
// A new cuboid enters the sine pipeline while earlier ones are still in work.
// Reset clears the matrix to zero and empties every pipeline stage.
// When the receiver stalls, the whole corner pipeline holds its contents and
// in_stall rises once a cuboid waits at the head of the sine pipeline.
`timescale 1ns / 1ps

module cuboid_corner_projection
    import ccp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           cuboid_id,
    input  logic [30:0]          half_x,
    input  logic [30:0]          half_y,
    input  logic signed [31:0]   box_height,
    input  logic signed [31:0]   centre_x,
    input  logic signed [31:0]   centre_y,
    input  logic [15:0]          yaw,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           cuboid_tag,
    output logic [2:0]           corner_index,
    output logic signed [31:0]   world_x,
    output logic signed [31:0]   world_y,
    output logic signed [31:0]   world_z,
    output logic signed [31:0]   image_u,
    output logic signed [31:0]   image_v,
    output logic                 zero_depth,
    output logic                 clipped,
    output logic                 last_corner
);

    logic [63:0]        cfg_reg [0:REG_COUNT-1];
    mat_t               mat;
    cuboid_t            a_data_reg [0:TRIG_STAGES-1];
    logic               a_vld_reg [0:TRIG_STAGES-1];
    logic               en_a;
    logic               take;
    logic               id_ok;
    cuboid_t            in_cub;
    logic signed [17:0] sin_val;
    logic signed [17:0] cos_val;
    logic               adv;
    logic               corner_valid;
    corner_t            corner;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                cfg_reg[i] <= 64'd0;
            end
        end
        else if (cfg_write && ({29'd0, cfg_index} < REG_COUNT))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Matrix entry (row, col) sits in register 2 * row + col / 2.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            mat[r * 4]     = cfg_reg[r * 2][31:0];
            mat[r * 4 + 1] = cfg_reg[r * 2][63:32];
            mat[r * 4 + 2] = cfg_reg[r * 2 + 1][31:0];
            mat[r * 4 + 3] = cfg_reg[r * 2 + 1][63:32];
        end
    end

    // Sine stage line moves unless its head waits on the sequencer.
    assign en_a     = !a_vld_reg[TRIG_STAGES-1] || take;
    assign in_stall = !en_a;
    assign id_ok    = ({1'b0, cuboid_id} < 9'(CUBOID_COUNT));

    always_comb
    begin
        in_cub.id = cuboid_id;
        in_cub.hx = half_x;
        in_cub.hy = half_y;
        in_cub.h  = box_height;
        in_cub.cx = centre_x;
        in_cub.cy = centre_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TRIG_STAGES; i++)
            begin
                a_vld_reg[i] <= 1'b0;
            end
        end
        else if (en_a)
        begin
            a_vld_reg[0] <= in_valid && id_ok;
            for (int i = 1; i < TRIG_STAGES; i++)
            begin
                a_vld_reg[i] <= a_vld_reg[i - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_data_reg[0] <= in_cub;
            for (int i = 1; i < TRIG_STAGES; i++)
            begin
                a_data_reg[i] <= a_data_reg[i - 1];
            end
        end
    end

    // Sine and cosine lanes run beside the cuboid payload.
    ccp_sine_pipe u_sin (
        .clk   (clk),
        .en    (en_a),
        .angle (yaw),
        .value (sin_val)
    );

    ccp_sine_pipe u_cos (
        .clk   (clk),
        .en    (en_a),
        .angle (yaw + QUARTER_TURN),
        .value (cos_val)
    );

    ccp_corner_gen u_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (a_vld_reg[TRIG_STAGES-1]),
        .src          (a_data_reg[TRIG_STAGES-1]),
        .src_sin      (sin_val),
        .src_cos      (cos_val),
        .adv          (adv),
        .take         (take),
        .corner_valid (corner_valid),
        .corner       (corner)
    );

    ccp_project_pipe u_proj (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (corner_valid),
        .in_corner    (corner),
        .mat          (mat),
        .out_stall    (out_stall),
        .adv          (adv),
        .out_valid    (out_valid),
        .cuboid_tag   (cuboid_tag),
        .corner_index (corner_index),
        .world_x      (world_x),
        .world_y      (world_y),
        .world_z      (world_z),
        .image_u      (image_u),
        .image_v      (image_v),
        .zero_depth   (zero_depth),
        .clipped      (clipped),
        .last_corner  (last_corner)
    );

endmodule

// File: design/ccp_checker.sv
// Port-level checker for the cuboid corner projection block and its bind.
`timescale 1ns / 1ps

module ccp_checker
    import ccp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [7:0]           cuboid_tag,
    input logic [2:0]           corner_index,
    input logic                 last_corner
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // The last-corner flag marks corner seven only.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_corner == (corner_index == LAST_INDEX)))
        else $error("last_corner does not match corner_index");

    // Corners of one cuboid follow each other without gaps.
    a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_corner |=>
            out_valid && (corner_index == $past(corner_index) + 3'd1)
            && (cuboid_tag == $past(cuboid_tag)))
        else $error("corner sequence broken");

endmodule

bind cuboid_corner_projection ccp_checker u_ccp_checker (.*);
